// ===== hw/rtl/ogfs_pkg.sv =====
// Shared constants, controller/datapath command and status types and a bounds helper
// for the occupancy grid free cell search. No dependencies.
`default_nettype none

package ogfs_pkg;

	localparam int MAX_COLS_DEF = 128;
	localparam int MAX_ROWS_DEF = 128;

	// input item operation codes
	localparam logic [1:0] FUNC_WR_OBS = 2'd0;
	localparam logic [1:0] FUNC_WR_ENT = 2'd1;
	localparam logic [1:0] FUNC_FIND   = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RADIUS = 2'd2;

	localparam logic [7:0] GRID_WIDTH_RST    = 8'd100;
	localparam logic [7:0] GRID_HEIGHT_RST   = 8'd100;
	localparam logic [6:0] SEARCH_RADIUS_RST = 7'd50;

	typedef struct packed {
		logic clr;       // clear one cell of both maps
		logic wr_obs;    // write obstacle layer from the input item
		logic wr_ent;    // write entity layer from the input item
		logic start;     // capture query origin, reset candidate walk
		logic run;       // issue current candidate, advance walk
		logic hit_cap;   // latch stage-2 hit as the query result
		logic out_load;  // move query result into output register
	} ogfs_cmd_t;

	typedef struct packed {
		logic clr_last;  // clearing pass is at its final cell
		logic gen_last;  // current candidate is the final one of the search
		logic hit;       // stage 2 holds a free in-bounds cell
		logic pipe_busy; // candidates still in flight
	} ogfs_stat_t;

	// v is inside min(lim, maxv)
	function automatic logic coord_ok(input logic [7:0] v, input logic [7:0] lim,
			input int maxv);
		return (v < lim) && ({3'b000, v} < 11'(maxv));
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ogfs_ctrl.sv =====
// Controller state machine for the free cell search: clearing pass, write/query
// dispatch, search sequencing and output register handshake. Uses ogfs_pkg.
`default_nettype none

module ogfs_ctrl import ogfs_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] func,
	output logic            out_valid,
	input  wire logic       out_ready,
	output ogfs_cmd_t       cmd,
	input  wire ogfs_stat_t stat
);

	localparam logic [2:0] ST_CLEAR  = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_SEARCH = 3'd2;
	localparam logic [2:0] ST_DRAIN  = 3'd3;
	localparam logic [2:0] ST_DONE   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       accept;
	logic       searching;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign searching = (state_q == ST_SEARCH) || (state_q == ST_DRAIN);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.clr      = (state_q == ST_CLEAR);
		cmd.wr_obs   = accept && (func == FUNC_WR_OBS);
		cmd.wr_ent   = accept && (func == FUNC_WR_ENT);
		cmd.start    = accept && (func == FUNC_FIND);
		cmd.run      = (state_q == ST_SEARCH);
		cmd.hit_cap  = searching && stat.hit;
		cmd.out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (stat.clr_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd.start) state_d = ST_SEARCH;
			end
			ST_SEARCH: begin
				if (stat.hit) state_d = ST_DONE;
				else if (stat.gen_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				// wait for in-flight candidates before reporting not found
				if (stat.hit || !stat.pipe_busy) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (cmd.out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ogfs_dp.sv =====
// Datapath for the free cell search: configuration registers, the two occupancy
// maps, the ring candidate walk, a two-stage lookup pipeline and result registers.
// Uses ogfs_pkg.
`default_nettype none

module ogfs_dp import ogfs_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ogfs_cmd_t            cmd,
	output ogfs_stat_t                stat,
	input  wire logic                 cfg_wr,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data,
	input  wire logic [6:0]           col,
	input  wire logic [6:0]           row,
	input  wire logic                 occupied,
	output logic                      found,
	output logic [6:0]                free_col,
	output logic [6:0]                free_row
);

	localparam int DEPTH = MAX_COLS * MAX_ROWS;
	localparam int AW    = $clog2(DEPTH);

	function automatic logic [AW-1:0] cell_addr(input logic [7:0] c, input logic [7:0] r);
		return AW'(r) * AW'(MAX_COLS) + AW'(c);
	endfunction

	// configuration
	logic [7:0] grid_width_q;
	logic [7:0] grid_height_q;
	logic [6:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
			radius_q      <= SEARCH_RADIUS_RST;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_GRID_WIDTH:    grid_width_q  <= cfg_data;
				REG_GRID_HEIGHT:   grid_height_q <= cfg_data;
				REG_SEARCH_RADIUS: radius_q      <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// clearing pass counter
	logic [AW-1:0] clr_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_cnt_q <= '0;
		else if (cmd.clr) clr_cnt_q <= clr_cnt_q + AW'(1);
	end

	// candidate walk: origin, then rings with dx outer and dy inner
	logic [6:0]        org_col_q;
	logic [6:0]        org_row_q;
	logic [6:0]        rad_q;
	logic signed [7:0] dx_q;
	logic signed [7:0] dy_q;
	logic signed [7:0] rad_s;
	logic signed [7:0] neg_rad;
	logic              on_side;

	assign rad_s   = signed'({1'b0, rad_q});
	assign neg_rad = -rad_s;
	assign on_side = (dx_q == rad_s) || (dx_q == neg_rad);

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			org_col_q <= col;
			org_row_q <= row;
			rad_q     <= '0;
			dx_q      <= '0;
			dy_q      <= '0;
		end else if (cmd.run) begin
			if (dy_q == rad_s) begin
				if (dx_q == rad_s) begin
					// next ring starts at its lower-left corner
					rad_q <= rad_q + 7'd1;
					dx_q  <= signed'(~{1'b0, rad_q});
					dy_q  <= signed'(~{1'b0, rad_q});
				end else begin
					dx_q <= dx_q + 8'sd1;
					dy_q <= neg_rad;
				end
			end else if (on_side) begin
				dy_q <= dy_q + 8'sd1;
			end else begin
				// interior column: jump to the top edge
				dy_q <= rad_s;
			end
		end
	end

	// stage 1: candidate coordinates, bounds and address
	logic [8:0]    cand_c;
	logic [8:0]    cand_r;
	logic          cand_inb;
	logic          v_s1;
	logic          inb_s1;
	logic [AW-1:0] addr_s1;
	logic [6:0]    col_s1;
	logic [6:0]    row_s1;

	assign cand_c   = {2'b00, org_col_q} + {dx_q[7], dx_q};
	assign cand_r   = {2'b00, org_row_q} + {dy_q[7], dy_q};
	assign cand_inb = !cand_c[8] && !cand_r[8]
		&& coord_ok(cand_c[7:0], grid_width_q, MAX_COLS)
		&& coord_ok(cand_r[7:0], grid_height_q, MAX_ROWS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= cmd.run;
	end

	always_ff @(posedge clk) begin
		inb_s1  <= cand_inb;
		addr_s1 <= cell_addr(cand_c[7:0], cand_r[7:0]);
		col_s1  <= cand_c[6:0];
		row_s1  <= cand_r[6:0];
	end

	// occupancy maps
	logic          obs_mem [DEPTH];
	logic          ent_mem [DEPTH];
	logic [AW-1:0] wr_addr;
	logic          wr_inb;

	assign wr_addr = cell_addr({1'b0, col}, {1'b0, row});
	assign wr_inb  = coord_ok({1'b0, col}, grid_width_q, MAX_COLS)
		&& coord_ok({1'b0, row}, grid_height_q, MAX_ROWS);

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			obs_mem[clr_cnt_q] <= 1'b0;
			ent_mem[clr_cnt_q] <= 1'b0;
		end else begin
			// obstacle cells can only be set
			if (cmd.wr_obs && wr_inb && occupied) obs_mem[wr_addr] <= 1'b1;
			if (cmd.wr_ent && wr_inb) ent_mem[wr_addr] <= occupied;
		end
	end

	// stage 2: registered map read
	logic       v_s2;
	logic       inb_s2;
	logic [6:0] col_s2;
	logic [6:0] row_s2;
	logic       obs_s2;
	logic       ent_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1 && !cmd.start;
	end

	always_ff @(posedge clk) begin
		obs_s2 <= obs_mem[addr_s1];
		ent_s2 <= ent_mem[addr_s1];
		inb_s2 <= inb_s1;
		col_s2 <= col_s1;
		row_s2 <= row_s1;
	end

	// query result and output register
	logic       res_found_q;
	logic [6:0] res_col_q;
	logic [6:0] res_row_q;
	logic       found_q;
	logic [6:0] free_col_q;
	logic [6:0] free_row_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			res_found_q <= 1'b0;
			res_col_q   <= '0;
			res_row_q   <= '0;
		end else if (cmd.hit_cap) begin
			res_found_q <= 1'b1;
			res_col_q   <= col_s2;
			res_row_q   <= row_s2;
		end
		if (cmd.out_load) begin
			found_q    <= res_found_q;
			free_col_q <= res_col_q;
			free_row_q <= res_row_q;
		end
	end

	assign found    = found_q;
	assign free_col = free_col_q;
	assign free_row = free_row_q;

	always_comb begin
		stat.clr_last  = (clr_cnt_q == AW'(DEPTH - 1));
		stat.gen_last  = (rad_q == radius_q) && (dx_q == rad_s) && (dy_q == rad_s);
		stat.hit       = v_s2 && inb_s2 && !obs_s2 && !ent_s2;
		stat.pipe_busy = v_s1 || v_s2;
	end

endmodule

`default_nettype wire

// ===== hw/rtl/occupancy_grid_free_cell_search_top.sv =====
// A map write gives no result. A query tests one cell a cycle through the map
// read port: the origin, then up to 8*r cells per ring r, at most (2R+1)^2 cells.
// A free cell passes the stage-1 and stage-2 registers, is latched as the query
// result and then loaded into the output register. Throughput: one item at a time.
// Reset: configuration returns to 100 x 100 with radius 50, and a clearing pass
// zeroes both maps, MAX_COLS*MAX_ROWS cells (16384 by default), before items are taken.
`default_nettype none

module occupancy_grid_free_cell_search_top import ogfs_pkg::*; #(
	parameter int MAX_COLS = MAX_COLS_DEF,
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [1:0]           func,
	input  wire logic [6:0]           col,
	input  wire logic [6:0]           row,
	input  wire logic                 occupied,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic                      found,
	output logic [6:0]                free_col,
	output logic [6:0]                free_row,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DAT_W-1:0] cfg_data
);

	ogfs_cmd_t  cmd;
	ogfs_stat_t stat;

	assign cfg_ready = 1'b1;

	ogfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	ogfs_dp #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.col       (col),
		.row       (row),
		.occupied  (occupied),
		.found     (found),
		.free_col  (free_col),
		.free_row  (free_row)
	);

endmodule

`default_nettype wire
